// File: design/range_add_max_segment_tree_macros.svh
// Assertion macros used by the range-add / range-max tree top level.
`ifndef RANGE_ADD_MAX_SEGMENT_TREE_MACROS_SVH
`define RANGE_ADD_MAX_SEGMENT_TREE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define RAMST_ASSERT_NOW(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define RAMST_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: design/ramst_pkg.sv
// Package: constants, node entry type and helpers for the range-add / range-max tree.
package ramst_pkg;

   localparam int DEF_LEAVES = 1024;
   localparam logic [10:0] N_USED_RESET = 11'd1024;
   localparam logic [63:0] SENTINEL = 64'hE000_0000_0000_0000;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   typedef struct packed {
      logic [63:0] max_v;
      logic [63:0] add_v;
   } entry_type;

   function automatic logic [63:0] smax(input logic [63:0] a, input logic [63:0] b);
      return ($signed(a) >= $signed(b)) ? a : b;
   endfunction

endpackage

// File: design/ramst_node_ram.sv
// Node store: one write port, one read port, registered read data.
module ramst_node_ram #(
   parameter int DEPTH = 2 * ramst_pkg::DEF_LEAVES,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output ramst_pkg::entry_type rd_data,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  ramst_pkg::entry_type wr_data
);

   ramst_pkg::entry_type mem [DEPTH];
   ramst_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/range_add_max_segment_tree.sv
// Top level: lazy segment tree with range add, range max and leaf load.
// Usage: each item is a command (load leaf, range add, range max query, no-op) and
// yields exactly one result item. After reset the block runs a clearing pass over
// all 2*LEAVES node addresses (one node per cycle) with req_stall high; config
// writes are taken meanwhile. Items are processed one at a time. The tree walk is
// a stack sequencer around one node memory (one read and one write per cycle,
// registered read data): a visited node is skipped when disjoint, read when covered
// by a query and rewritten when covered by an add or load; a split node has its
// pending add pushed into both children, and a split by an add or load then pulls
// the children's maxima back into it. Rejected loads and empty ranges go straight
// to the result. A finished result waits in the rsp register while the next item
// is accepted.
module range_add_max_segment_tree #(
   parameter int LEAVES = ramst_pkg::DEF_LEAVES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [10:0] req_range_low,
   input  logic [10:0] req_range_high,
   input  logic [63:0] req_operand_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_max_value,
   output logic        rsp_status,
   input  logic        csr_write_enable,
   input  logic [10:0] csr_write_data
);

`include "range_add_max_segment_tree_macros.svh"

   // widths: positions 1..LEAVES, nodes 1..2*LEAVES-1, stack one frame per level
   localparam int PW = $clog2(LEAVES) + 1;
   localparam int XW = (PW > 11) ? PW : 11;
   localparam int NW = $clog2(LEAVES) + 1;
   localparam int D  = $clog2(LEAVES) + 1;
   localparam int SW = $clog2(D);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_VISIT  = 4'd2;
   localparam logic [3:0] S_QRD    = 4'd3;
   localparam logic [3:0] S_ARD    = 4'd4;
   localparam logic [3:0] S_PD0    = 4'd5;
   localparam logic [3:0] S_PD1    = 4'd6;
   localparam logic [3:0] S_PD2    = 4'd7;
   localparam logic [3:0] S_PD3    = 4'd8;
   localparam logic [3:0] S_RESUME = 4'd9;
   localparam logic [3:0] S_PU0    = 4'd10;
   localparam logic [3:0] S_PU1    = 4'd11;
   localparam logic [3:0] S_POP    = 4'd12;
   localparam logic [3:0] S_FIN    = 4'd13;

   // frame phase: 0 fresh, 1 left child running, 2 right child running
   localparam logic [1:0] PH_NEW   = 2'd0;
   localparam logic [1:0] PH_LEFT  = 2'd1;
   localparam logic [1:0] PH_RIGHT = 2'd2;

   logic [3:0]    state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [10:0]   n_used_ff, n_used_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [XW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [63:0]   val_ff, val_in;
   logic [63:0]   ret_ff, ret_in;
   logic [63:0]   sav_ff, sav_in;
   logic [63:0]   pend_ff, pend_in;
   logic [63:0]   res_max_ff, res_max_in;
   logic          res_st_ff, res_st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_max_ff, rsp_max_in;
   logic          rsp_status_ff, rsp_status_in;
   logic [SW-1:0] sp_ff, sp_in;

   // traversal stack, one frame per tree level
   logic [NW-1:0] nd_stk_ff [D];
   logic [NW-1:0] nd_stk_in [D];
   logic [PW-1:0] st_stk_ff [D];
   logic [PW-1:0] st_stk_in [D];
   logic [PW-1:0] en_stk_ff [D];
   logic [PW-1:0] en_stk_in [D];
   logic [1:0]    ph_stk_ff [D];
   logic [1:0]    ph_stk_in [D];
   logic [63:0]   acc_stk_ff [D];
   logic [63:0]   acc_stk_in [D];

   logic                 rd_en, wr_en;
   logic [NW-1:0]        rd_addr, wr_addr;
   ramst_pkg::entry_type rd_data, wr_data;

   logic [NW-1:0] cur_nd, left_nd, right_nd;
   logic [PW-1:0] cur_st, cur_en, mid, mid1;
   logic [PW:0]   span_sum;
   logic [XW-1:0] st_x, en_x, req_lo_x, req_hi_x;
   logic          disjoint, covered, bad_load;
   logic [SW-1:0] sp_up;

   ramst_node_ram #(
      .DEPTH (2 * LEAVES),
      .AW    (NW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign cur_nd   = nd_stk_ff[sp_ff];
   assign cur_st   = st_stk_ff[sp_ff];
   assign cur_en   = en_stk_ff[sp_ff];
   assign left_nd  = {cur_nd[NW-2:0], 1'b0};
   assign right_nd = {cur_nd[NW-2:0], 1'b1};
   assign span_sum = {1'b0, cur_st} + {1'b0, cur_en};
   assign mid      = span_sum[PW:1];
   assign mid1     = mid + PW'(1);
   assign st_x     = XW'(cur_st);
   assign en_x     = XW'(cur_en);
   assign disjoint = (lo_ff > en_x) || (hi_ff < st_x);
   assign covered  = (lo_ff <= st_x) && (en_x <= hi_ff);
   assign sp_up    = sp_ff + SW'(1);

   assign req_lo_x = XW'(req_range_low);
   assign req_hi_x = XW'(req_range_high);
   assign bad_load = (req_command == ramst_pkg::CMD_LOAD) &&
                     ((req_lo_x == '0) || (req_lo_x > XW'(n_used_ff)) ||
                      (req_lo_x > XW'(LEAVES)));

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      n_used_in     = n_used_ff;
      cmd_in        = cmd_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      val_in        = val_ff;
      ret_in        = ret_ff;
      sav_in        = sav_ff;
      pend_in       = pend_ff;
      res_max_in    = res_max_ff;
      res_st_in     = res_st_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_max_in    = rsp_max_ff;
      rsp_status_in = rsp_status_ff;
      sp_in         = sp_ff;
      nd_stk_in     = nd_stk_ff;
      st_stk_in     = st_stk_ff;
      en_stk_in     = en_stk_ff;
      ph_stk_in     = ph_stk_ff;
      acc_stk_in    = acc_stk_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_nd;
      wr_en         = 1'b0;
      wr_addr       = cur_nd;
      wr_data       = '{max_v: ramst_pkg::SENTINEL, add_v: 64'd0};

      if (csr_write_enable) begin
         n_used_in = csr_write_data;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + NW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               lo_in     = req_lo_x;
               hi_in     = (req_command == ramst_pkg::CMD_LOAD) ? req_lo_x : req_hi_x;
               val_in    = req_operand_value;
               res_st_in = 1'b0;
               if (bad_load) begin
                  res_max_in = 64'd0;
                  res_st_in  = 1'b1;
                  state_in   = S_FIN;
               end else if (req_command == ramst_pkg::CMD_NONE) begin
                  res_max_in = 64'd0;
                  state_in   = S_FIN;
               end else if (req_command != ramst_pkg::CMD_LOAD && req_lo_x > req_hi_x) begin
                  res_max_in = (req_command == ramst_pkg::CMD_QUERY) ?
                               ramst_pkg::SENTINEL : 64'd0;
                  state_in   = S_FIN;
               end else begin
                  sp_in        = '0;
                  nd_stk_in[0] = NW'(1);
                  st_stk_in[0] = PW'(1);
                  en_stk_in[0] = PW'(LEAVES);
                  ph_stk_in[0] = PH_NEW;
                  state_in     = S_VISIT;
               end
            end
         end
         S_VISIT: begin
            if (disjoint) begin
               ret_in   = ramst_pkg::SENTINEL;
               state_in = S_POP;
            end else if (covered) begin
               rd_en    = 1'b1;
               state_in = (cmd_ff == ramst_pkg::CMD_QUERY) ? S_QRD : S_ARD;
            end else begin
               rd_en    = 1'b1;
               state_in = S_PD0;
            end
         end
         S_QRD: begin
            ret_in   = rd_data.max_v;
            state_in = S_POP;
         end
         S_ARD: begin
            wr_en = 1'b1;
            if (cmd_ff == ramst_pkg::CMD_LOAD) begin
               wr_data = '{max_v: val_ff, add_v: rd_data.add_v};
            end else begin
               wr_data = '{max_v: rd_data.max_v + val_ff, add_v: rd_data.add_v + val_ff};
            end
            state_in = S_POP;
         end
         S_PD0: begin
            // split node: keep its max, hand its pending add to both children
            sav_in   = rd_data.max_v;
            pend_in  = rd_data.add_v;
            rd_en    = 1'b1;
            rd_addr  = left_nd;
            state_in = S_PD1;
         end
         S_PD1: begin
            wr_en    = 1'b1;
            wr_addr  = left_nd;
            wr_data  = '{max_v: rd_data.max_v + pend_ff, add_v: rd_data.add_v + pend_ff};
            rd_en    = 1'b1;
            rd_addr  = right_nd;
            state_in = S_PD2;
         end
         S_PD2: begin
            wr_en    = 1'b1;
            wr_addr  = right_nd;
            wr_data  = '{max_v: rd_data.max_v + pend_ff, add_v: rd_data.add_v + pend_ff};
            state_in = S_PD3;
         end
         S_PD3: begin
            wr_en            = 1'b1;
            wr_data          = '{max_v: sav_ff, add_v: 64'd0};
            ph_stk_in[sp_ff] = PH_LEFT;
            nd_stk_in[sp_up] = left_nd;
            st_stk_in[sp_up] = cur_st;
            en_stk_in[sp_up] = mid;
            ph_stk_in[sp_up] = PH_NEW;
            sp_in            = sp_up;
            state_in         = S_VISIT;
         end
         S_RESUME: begin
            if (ph_stk_ff[sp_ff] == PH_LEFT) begin
               acc_stk_in[sp_ff] = ret_ff;
               ph_stk_in[sp_ff]  = PH_RIGHT;
               nd_stk_in[sp_up]  = right_nd;
               st_stk_in[sp_up]  = mid1;
               en_stk_in[sp_up]  = cur_en;
               ph_stk_in[sp_up]  = PH_NEW;
               sp_in             = sp_up;
               state_in          = S_VISIT;
            end else if (cmd_ff == ramst_pkg::CMD_QUERY) begin
               ret_in   = ramst_pkg::smax(acc_stk_ff[sp_ff], ret_ff);
               state_in = S_POP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = left_nd;
               state_in = S_PU0;
            end
         end
         S_PU0: begin
            sav_in   = rd_data.max_v;
            rd_en    = 1'b1;
            rd_addr  = right_nd;
            state_in = S_PU1;
         end
         S_PU1: begin
            // pending add of a split node is zero until it is written again here
            wr_en    = 1'b1;
            wr_data  = '{max_v: ramst_pkg::smax(sav_ff, rd_data.max_v), add_v: 64'd0};
            state_in = S_POP;
         end
         S_POP: begin
            if (sp_ff == '0) begin
               res_max_in = (cmd_ff == ramst_pkg::CMD_QUERY) ? ret_ff : 64'd0;
               state_in   = S_FIN;
            end else begin
               sp_in    = sp_ff - SW'(1);
               state_in = S_RESUME;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_max_in    = res_max_ff;
               rsp_status_in = res_st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         n_used_ff    <= ramst_pkg::N_USED_RESET;
         rsp_valid_ff <= 1'b0;
         sp_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         n_used_ff    <= n_used_in;
         rsp_valid_ff <= rsp_valid_in;
         sp_ff        <= sp_in;
      end
      cmd_ff        <= cmd_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      val_ff        <= val_in;
      ret_ff        <= ret_in;
      sav_ff        <= sav_in;
      pend_ff       <= pend_in;
      res_max_ff    <= res_max_in;
      res_st_ff     <= res_st_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_status_ff <= rsp_status_in;
      nd_stk_ff     <= nd_stk_in;
      st_stk_ff     <= st_stk_in;
      en_stk_ff     <= en_stk_in;
      ph_stk_ff     <= ph_stk_in;
      acc_stk_ff    <= acc_stk_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_status    = rsp_status_ff;

   `RAMST_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall, state_ff != S_IDLE, "accepted item did not start work")
   `RAMST_ASSERT_NOW(a_stack_depth, clock, reset, sp_ff <= SW'(D - 1), "traversal stack overflow")
   `RAMST_ASSERT_NOW(a_no_same_cycle_rw, clock, reset, !(rd_en && wr_en && rd_addr == wr_addr), "node read and write collide")

endmodule

// File: sim/tb.sv
// Testbench for the range-add / range-max lazy segment tree.
`timescale 1ns / 100ps

module tb;

   localparam int NLEAF = 1024;
   localparam int NNODE = 2 * NLEAF;
   localparam int LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = ramst_pkg::CMD_LOAD;
   logic [10:0] req_range_low = '0;
   logic [10:0] req_range_high = '0;
   logic [63:0] req_operand_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_max_value;
   logic        rsp_status;
   logic        csr_write_enable = 1'b0;
   logic [10:0] csr_write_data = '0;

   range_add_max_segment_tree u_top (.*);

   always #1 clock = ~clock;

   // One stimulus row; has_exp marks rows whose result is typed in directly.
   typedef struct {
      logic [1:0]  cmd;
      logic [10:0] lo;
      logic [10:0] hi;
      logic [63:0] val;
      bit          has_exp;
      logic [63:0] exp_max;
      logic        exp_status;
   } row_type;

   typedef struct {
      logic [63:0] max_v;
      logic        status;
   } answer_type;

   // Predictor state
   logic [63:0] tmax [NNODE];
   logic [63:0] tadd [NNODE];
   bit          tflag [NNODE];
   int unsigned leaf_limit;

   answer_type answers[$];
   int  errors = 0;
   int  cycles = 0;
   bit  rsp_idle_on = 1'b1;
   bit  req_idle_on = 1'b1;

   function automatic logic [63:0] bigger(logic [63:0] a, logic [63:0] b);
      return ($signed(a) >= $signed(b)) ? a : b;
   endfunction

   function automatic void bump(int nd, logic [63:0] v);
      tmax[nd] += v;
      tadd[nd] += v;
      tflag[nd] = 1'b1;
   endfunction

   function automatic void push(int nd);
      if (nd >= NLEAF || !tflag[nd]) return;
      bump(2 * nd, tadd[nd]);
      bump(2 * nd + 1, tadd[nd]);
      tadd[nd] = '0;
      tflag[nd] = 1'b0;
   endfunction

   function automatic void add_span(int nd, int st, int en, int lo, int hi, logic [63:0] v);
      int mid;
      if (lo > en || hi < st) return;
      if (lo <= st && en <= hi) begin
         bump(nd, v);
         return;
      end
      push(nd);
      mid = (st + en) >> 1;
      add_span(2 * nd, st, mid, lo, hi, v);
      add_span(2 * nd + 1, mid + 1, en, lo, hi, v);
      tmax[nd] = bigger(tmax[2 * nd], tmax[2 * nd + 1]);
   endfunction

   function automatic logic [63:0] max_span(int nd, int st, int en, int lo, int hi);
      int mid;
      logic [63:0] l, r;
      if (lo > en || hi < st) return ramst_pkg::SENTINEL;
      if (lo <= st && en <= hi) return tmax[nd];
      push(nd);
      mid = (st + en) >> 1;
      l = max_span(2 * nd, st, mid, lo, hi);
      r = max_span(2 * nd + 1, mid + 1, en, lo, hi);
      return bigger(l, r);
   endfunction

   function automatic void put_leaf(int pos, logic [63:0] v);
      int nd, st, en, mid;
      nd = 1; st = 1; en = NLEAF;
      while (nd < NLEAF) begin
         mid = (st + en) >> 1;
         push(nd);
         if (pos <= mid) begin
            nd = 2 * nd; en = mid;
         end else begin
            nd = 2 * nd + 1; st = mid + 1;
         end
      end
      tmax[nd] = v;
      nd >>= 1;
      while (nd >= 1) begin
         tmax[nd] = bigger(tmax[2 * nd], tmax[2 * nd + 1]);
         nd >>= 1;
      end
   endfunction

   function automatic answer_type tree_step(logic [1:0] cmd, int lo, int hi, logic [63:0] v);
      answer_type a;
      a.max_v = '0;
      a.status = 1'b0;
      case (cmd)
         ramst_pkg::CMD_LOAD: begin
            if (lo == 0 || lo > leaf_limit || lo > NLEAF) a.status = 1'b1;
            else put_leaf(lo, v);
         end
         ramst_pkg::CMD_ADD: begin
            if (lo <= hi) add_span(1, 1, NLEAF, lo, hi, v);
         end
         ramst_pkg::CMD_QUERY: begin
            a.max_v = (lo <= hi) ? max_span(1, 1, NLEAF, lo, hi) : ramst_pkg::SENTINEL;
         end
         default: ;
      endcase
      return a;
   endfunction

   // Result checker and stall generator
   always @(posedge clock) begin
      answer_type want;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers.size() == 0) begin
            $display("%0t: unexpected item max=%h status=%b", $time, rsp_max_value,
                     rsp_status);
            errors++;
         end else begin
            want = answers.pop_front();
            if (rsp_max_value !== want.max_v) begin
               $display("%0t: max_value expected %h actual %h", $time, want.max_v,
                        rsp_max_value);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %b actual %b", $time, want.status,
                        rsp_status);
               errors++;
            end
         end
      end
      rsp_stall <= rsp_idle_on && ($urandom_range(99) < 32);
   end

   task automatic tick();
      @(posedge clock);
   endtask

   // Drive one item and hold it until the block takes it; valid is dropped by
   // the next idle cycle or by drain.
   task automatic send(logic [1:0] cmd, logic [10:0] lo, logic [10:0] hi, logic [63:0] v);
      answer_type a;
      while (req_idle_on && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         tick();
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_range_low <= lo;
      req_range_high <= hi;
      req_operand_value <= v;
      tick();
      while (req_stall) tick();
      a = tree_step(cmd, lo, hi, v);
      answers.push_back(a);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (answers.size() != 0) tick();
      repeat (200) tick();
   endtask

   task automatic set_limit(int unsigned n);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= n[10:0];
      tick();
      csr_write_enable <= 1'b0;
      leaf_limit = n & 11'h7FF;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [10:0] rand_pos();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 4) return 11'($urandom_range(2047));
      if (p < 8) return 11'd0;
      if (p < 12) return 11'd1024;
      return 11'($urandom_range(1, 64));
   endfunction

   row_type directed[$];

   initial begin
      row_type r;
      logic [1:0] c;
      logic [10:0] lo, hi;
      int unsigned p;
      for (int i = 0; i < NNODE; i++) begin
         tmax[i] = ramst_pkg::SENTINEL; tadd[i] = '0; tflag[i] = 1'b0;
      end
      leaf_limit = ramst_pkg::N_USED_RESET;

      // Directed rows: command, low, high, value, typed-in result
      directed = '{
         '{ramst_pkg::CMD_QUERY, 11'd1, 11'd1024, 64'd0, 1, ramst_pkg::SENTINEL, 1'b0},
         '{ramst_pkg::CMD_LOAD, 11'd0, 11'd0, 64'd5, 1, 64'd0, 1'b1},     // index zero
         '{ramst_pkg::CMD_LOAD, 11'd1025, 11'd0, 64'd5, 1, 64'd0, 1'b1},  // past tree
         '{ramst_pkg::CMD_LOAD, 11'd2047, 11'd0, 64'd5, 1, 64'd0, 1'b1},
         '{ramst_pkg::CMD_LOAD, 11'd1, 11'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1, 64'd0, 1'b0},
         '{ramst_pkg::CMD_LOAD, 11'd1024, 11'd0, 64'h8000_0000_0000_0000, 1, 64'd0, 1'b0},
         '{ramst_pkg::CMD_LOAD, 11'd512, 11'd0, 64'd100, 1, 64'd0, 1'b0},
         '{ramst_pkg::CMD_QUERY, 11'd1, 11'd1024, 64'd0, 0, 64'd0, 1'b0},
         // low above high
         '{ramst_pkg::CMD_QUERY, 11'd5, 11'd4, 64'd0, 1, ramst_pkg::SENTINEL, 1'b0},
         // misses tree
         '{ramst_pkg::CMD_QUERY, 11'd1025, 11'd2047, 64'd0, 1, ramst_pkg::SENTINEL, 1'b0},
         '{ramst_pkg::CMD_ADD, 11'd1, 11'd1, 64'd1, 1, 64'd0, 1'b0},      // wraps max leaf
         '{ramst_pkg::CMD_QUERY, 11'd1, 11'd1, 64'd0, 0, 64'd0, 1'b0},
         // clipped
         '{ramst_pkg::CMD_ADD, 11'd0, 11'd2047, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd0, 1'b0},
         '{ramst_pkg::CMD_ADD, 11'd9, 11'd3, 64'd7, 1, 64'd0, 1'b0},
         '{ramst_pkg::CMD_QUERY, 11'd0, 11'd2047, 64'd0, 0, 64'd0, 1'b0},
         '{ramst_pkg::CMD_ADD, 11'd700, 11'd800, 64'd1000, 1, 64'd0, 1'b0}, // unloaded
         '{ramst_pkg::CMD_QUERY, 11'd600, 11'd900, 64'd0, 0, 64'd0, 1'b0},
         '{ramst_pkg::CMD_QUERY, 11'd512, 11'd512, 64'd0, 0, 64'd0, 1'b0},
         '{ramst_pkg::CMD_NONE, 11'h7FF, 11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd0, 1'b0},
         '{ramst_pkg::CMD_QUERY, 11'd1024, 11'd1024, 64'd0, 0, 64'd0, 1'b0}
      };

      repeat (10) tick();
      reset <= 1'b0;

      foreach (directed[i]) begin
         r = directed[i];
         send(r.cmd, r.lo, r.hi, r.val);
         if (r.has_exp) begin
            // typed-in value must agree with the predictor as well
            if (answers[$].max_v !== r.exp_max || answers[$].status !== r.exp_status) begin
               $display("%0t: row %0d expected %h/%b actual %h/%b", $time, i, r.exp_max,
                        r.exp_status, answers[$].max_v, answers[$].status);
               errors++;
            end
         end
      end

      // Small limit: loads beyond it rejected
      set_limit(3);
      send(ramst_pkg::CMD_LOAD, 11'd3, 11'd0, 64'd9);
      send(ramst_pkg::CMD_LOAD, 11'd4, 11'd0, 64'd9);
      set_limit(1);
      send(ramst_pkg::CMD_LOAD, 11'd1, 11'd0, 64'd11);
      send(ramst_pkg::CMD_LOAD, 11'd2, 11'd0, 64'd11);
      set_limit(2047);
      send(ramst_pkg::CMD_LOAD, 11'd1024, 11'd0, 64'd12);
      set_limit(0);
      send(ramst_pkg::CMD_LOAD, 11'd1, 11'd0, 64'd13);

      // Random part in phases of different limits
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_limit(1024);
            1: set_limit($urandom_range(1, 64));
            2: set_limit(2047);
            3: set_limit(1);
            default: set_limit($urandom_range(1, 1024));
         endcase
         req_idle_on = (ph != 2);
         rsp_idle_on = (ph != 2);
         for (int k = 0; k < 140; k++) begin
            p = $urandom_range(99);
            c = (p < 35) ? ramst_pkg::CMD_LOAD : (p < 65) ? ramst_pkg::CMD_ADD :
                (p < 97) ? ramst_pkg::CMD_QUERY : ramst_pkg::CMD_NONE;
            lo = rand_pos();
            hi = rand_pos();
            if ($urandom_range(9) < 7 && lo > hi && c != ramst_pkg::CMD_LOAD) begin
               hi = lo; lo = rand_pos();
               if (lo > hi) lo = hi;
            end
            if (k == 70) drain();   // sender holds off until all answers are in
            send(c, lo, hi, ($urandom_range(3) == 0) ? rand64() :
                 {{48{$urandom_range(1)==1'b1}}, 16'($urandom())});
         end
      end

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      drain();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: range_add_max_segment_tree.f
+incdir+design
design/ramst_pkg.sv
design/ramst_node_ram.sv
design/range_add_max_segment_tree.sv
sim/tb.sv
